### rtl/core/lru_key_value_cache_top_assert.svh
// Assertion macros for the LRU key/value cache.
// Needs clk and arst_n in the scope that uses them; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LKV_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by the cell and the top level.
package lkv_pkg;

	typedef logic signed [31:0] word_t;

	// Command codes
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Register index of capacity_in_use
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic  cmd;
		word_t lookup_key;
		word_t write_value;
	} lkv_req_t;

	typedef struct packed {
		logic  hit;
		word_t read_value;
		logic  evicted;
	} lkv_rsp_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic look;     // register the key compare
		logic upd;      // apply the reorder
		logic hit;      // key found somewhere in the row
		logic put_miss; // put of a new key
		logic evict;    // drop the least recent entry
	} lkv_op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPDT = 3'b100
	} lkv_state_t;

endpackage

### rtl/core/lkv_cell.sv
// One recency slot of the LRU cache: key, value, valid mark and compare.
// Depends on lkv_pkg; takes its neighbour's contents when the row shifts.
module lkv_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  lkv_pkg::lkv_op_t op,
	input  lkv_pkg::word_t  req_key,
	input  logic            tail_hit,
	input  lkv_pkg::word_t  prev_key,
	input  lkv_pkg::word_t  prev_value,
	input  logic            prev_valid,
	output lkv_pkg::word_t  key,
	output lkv_pkg::word_t  value,
	output logic            valid,
	output logic            match
);
	import lkv_pkg::*;

	word_t key_q;
	word_t value_q;
	logic  valid_q;
	logic  match_q;
	logic  shift;

	// Take the neighbour on a hit at or below this slot, or on an insert
	// that reaches this slot
	always_comb begin
		shift = 1'b0;
		if (op.upd) begin
			if (op.hit) begin
				shift = tail_hit;
			end else if (op.put_miss) begin
				shift = op.evict ? valid_q : prev_valid;
			end
		end
	end

	// Control state: valid mark and registered compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (shift) begin
				valid_q <= prev_valid;
			end
			if (op.look) begin
				match_q <= valid_q && (key_q == req_key);
			end
		end
	end

	// Payload: no reset, only read once written
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign valid = valid_q;
	assign match = match_q;

endmodule

### rtl/core/lru_key_value_cache_top.sv
// Top level of the LRU key/value cache: sequencer, APB register and cell row.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_top_assert.svh.
//
//  port group   dir  handshake            payload
//  req          in   req_valid/req_ready  lkv_req_t (cmd, lookup_key, write_value)
//  rsp          out  rsp_valid/rsp_ready  lkv_rsp_t (hit, read_value, evicted)
//  apb          in   psel/penable/pwrite  paddr, pwdata, prdata (capacity_in_use)
//
// Each item is handled in steps: transfer into the request register, a compare in
// which every cell compares its key, and an update in which the row shifts and the
// result is loaded. The sequencer handles one item at a time.
// The next item is taken while a result still waits in the output register; the
// update cycle holds until that register is free.
// Reset clears all valid marks and the occupancy at once; no clearing pass.
module lru_key_value_cache_top #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// requests
	input  logic              req_valid,
	output logic              req_ready,
	input  lkv_pkg::lkv_req_t req,
	// results
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lkv_pkg::lkv_rsp_t rsp
);
	import lkv_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > 5) ? CW : 5;

	lkv_state_t    state_q;
	lkv_req_t      req_q;
	lkv_rsp_t      rsp_q;
	logic          rsp_valid_q;
	logic [4:0]    cap_q;
	logic [CW-1:0] count_q;

	lkv_op_t       op;
	logic          upd_go;
	logic [EW-1:0] eff_cap;
	logic [EW-1:0] count_ext;
	logic          hit;
	logic          evict;
	logic          put_miss;
	word_t         hit_value;
	word_t         new_value;

	logic  [CAPACITY-1:0] match_vec;
	logic  [CAPACITY-1:0] valid_vec;
	logic  [CAPACITY-1:0] tail_vec;
	word_t                key_vec   [CAPACITY];
	word_t                value_vec [CAPACITY];
	word_t                prev_key  [CAPACITY];
	word_t                prev_val  [CAPACITY];
	logic  [CAPACITY-1:0] prev_vld;

	// Register port: single capacity register, always ready
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
			cap_q <= pwdata[4:0];
		end
	end

	// Clamp capacity into 1..CAPACITY
	always_comb begin
		if (cap_q == 5'd0) begin
			eff_cap = EW'(1);
		end else if (EW'(cap_q) > EW'(CAPACITY)) begin
			eff_cap = EW'(CAPACITY);
		end else begin
			eff_cap = EW'(cap_q);
		end
	end
	assign count_ext = EW'(count_q);

	// Hit detection and hit value: keys are unique, so at most one match
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | (value_vec[i] & {32{match_vec[i]}});
		end
	end
	assign hit      = |match_vec;
	assign put_miss = (req_q.cmd == CMD_PUT) && !hit;
	assign evict    = put_miss && (count_ext >= eff_cap);
	assign new_value = (req_q.cmd == CMD_GET) ? hit_value : req_q.write_value;

	// Match at this slot or further down the row
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			tail_vec[i] = |(match_vec >> i);
		end
	end

	// Update proceeds once the output register is free
	assign upd_go = (state_q == ST_UPDT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		op.look     = (state_q == ST_LOOK);
		op.upd      = upd_go;
		op.hit      = hit;
		op.put_miss = put_miss;
		op.evict    = evict;
	end

	// Neighbour feed: slot 0 takes the accessed entry
	always_comb begin
		prev_key[0] = req_q.lookup_key;
		prev_val[0] = new_value;
		prev_vld[0] = 1'b1;
		for (int i = 1; i < CAPACITY; i++) begin
			prev_key[i] = key_vec[i-1];
			prev_val[i] = value_vec[i-1];
			prev_vld[i] = valid_vec[i-1];
		end
	end

	// Cell row, most recent first
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.req_key    (req_q.lookup_key),
			.tail_hit   (tail_vec[g]),
			.prev_key   (prev_key[g]),
			.prev_value (prev_val[g]),
			.prev_valid (prev_vld[g]),
			.key        (key_vec[g]),
			.value      (value_vec[g]),
			.valid      (valid_vec[g]),
			.match      (match_vec[g])
		);
	end

	// Sequencer
	assign req_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			// Raise on update, drop on transfer
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPDT;
				end
				ST_UPDT: begin
					if (upd_go) begin
						state_q     <= ST_IDLE;
						if (put_miss && !evict) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (upd_go) begin
			rsp_q.hit        <= hit;
			rsp_q.read_value <= ((req_q.cmd == CMD_GET) && hit) ? hit_value : '0;
			rsp_q.evicted    <= evict;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
`include "lru_key_value_cache_top_assert.svh"

	`LKV_ASSERT_SAME(a_match_unique, state_q == ST_UPDT, $onehot0(match_vec), "duplicate key in cache")
	`LKV_ASSERT_SAME(a_valid_count, 1'b1, $countones(valid_vec) == int'(count_q), "valid marks disagree with occupancy")
	`LKV_ASSERT_SAME(a_count_bound, 1'b1, count_ext <= EW'(CAPACITY), "occupancy above capacity")
	`LKV_ASSERT_NEXT(a_result_load, upd_go, rsp_valid_q, "result not loaded after update")
	`LKV_ASSERT_SAME(a_evict_miss, rsp_valid_q, !(rsp_q.evicted && rsp_q.hit), "eviction on a hit")

endmodule
